[rtl/slru_pkg.sv]
// ---------------------------------------------------------------------------
// slru_pkg
// Shared constants, codes, command and status types and fixed-point helpers
// of the sampled low-rank update engine.
// ---------------------------------------------------------------------------
`default_nettype none

package slru_pkg;

	localparam int ROWS     = 256;
	localparam int COLS     = 256;
	localparam int MAX_RANK = 64;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int RANK_W = $clog2(MAX_RANK);
	localparam int CNT_W  = RANK_W + 1;

	localparam int LEFT_DEPTH  = MAX_RANK * ROWS;
	localparam int RIGHT_DEPTH = MAX_RANK * COLS;

	localparam int WORD_W = 32;
	localparam int ACC_W  = 64;
	localparam int FRAC_W = 16;

	typedef enum logic [1:0] {
		FUNC_LEFT   = 2'd0,
		FUNC_RIGHT  = 2'd1,
		FUNC_SCALE  = 2'd2,
		FUNC_UPDATE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_BETA  = 2'd1,
		REG_RANK  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              ld_left;
		logic              ld_right;
		logic              ld_scale;
		logic              capture;
		logic              init_acc;
		logic              issue;
		logic [RANK_W-1:0] rank_pos;
		logic              load_out;
	} slru_cmd_t;

	typedef struct packed {
		logic             pipe_busy;
		logic [CNT_W-1:0] rank_eff;
	} slru_status_t;

	// true when a product shifted down by the fraction does not fit in a word
	function automatic logic q16_ovf(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-1:0] s;
		s = p >>> FRAC_W;
		return !((&s[ACC_W-1:WORD_W-1]) || !(|s[ACC_W-1:WORD_W-1]));
	endfunction

	// floor of p / 2^16, clamped to a signed word
	function automatic logic signed [WORD_W-1:0] q16_sat(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-1:0] s;
		s = p >>> FRAC_W;
		if (!q16_ovf(p)) begin
			return s[WORD_W-1:0];
		end else if (s[ACC_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

[rtl/sampled_low_rank_update.sv]
// ---------------------------------------------------------------------------
// sampled_low_rank_update
// Sampled low-rank update engine, signed Q16.16: factor and scale loads
// and per-nonzero updates new = old*beta + sum alpha*left*scale*right.
// ---------------------------------------------------------------------------
// A load beat (left factor, right factor or scale element) is written to
// its store and gives no result. An update beat holds off the next input
// beat until its result has moved to the output register: one rank
// position enters the four-stage multiply pipeline each cycle (rank is
// rank_used capped at 64, and none enter with rank zero), reading the
// left, right and scale memories through their single read ports, then the
// pipeline drains and the clamped sum moves to the output register, which
// waits further while an earlier result is still held there. Loads are taken
// while a result waits at the output. Store entries never written read back
// as undefined. Configuration writes are always ready and must only be made
// while idle.
`default_nettype none

module sampled_low_rank_update
	import slru_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               func,
	input  wire logic [7:0]               row_index,
	input  wire logic [7:0]               column_index,
	input  wire logic [5:0]               factor_index,
	input  wire logic signed [31:0]       data_word,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [31:0]            new_value,
	output logic                          saturated,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [31:0]              cfg_data
);

	slru_cmd_t    cmd;
	slru_status_t status;

	assign cfg_ready = 1'b1;

	slru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	slru_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.row_index    (row_index[ROW_W-1:0]),
		.column_index (column_index[COL_W-1:0]),
		.factor_index (factor_index[RANK_W-1:0]),
		.data_word    (data_word),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.new_value    (new_value),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire

[rtl/slru_ram.sv]
// ---------------------------------------------------------------------------
// slru_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module slru_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/slru_datapath.sv]
// ---------------------------------------------------------------------------
// slru_datapath
// Factor and scale stores, configuration registers, four-stage term
// pipeline, 64-bit accumulator and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module slru_datapath
	import slru_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire slru_cmd_t                  cmd,
	output slru_status_t                    status,
	input  wire logic [ROW_W-1:0]           row_index,
	input  wire logic [COL_W-1:0]           column_index,
	input  wire logic [RANK_W-1:0]          factor_index,
	input  wire logic signed [WORD_W-1:0]   data_word,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [WORD_W-1:0]          cfg_data,
	output logic signed [WORD_W-1:0]        new_value,
	output logic                            saturated
);

	logic signed [WORD_W-1:0] alpha_q;
	logic signed [WORD_W-1:0] beta_q;
	logic [CNT_W-1:0]         rank_used_q;

	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic                     row_ok_q;
	logic                     col_ok_q;
	logic signed [WORD_W-1:0] old_q;

	logic signed [WORD_W-1:0] lf_s1;
	logic signed [WORD_W-1:0] rf_s1;
	logic signed [WORD_W-1:0] sc_s1;
	logic signed [ACC_W-1:0]  p1_s2;
	logic signed [WORD_W-1:0] rf_s2;
	logic signed [WORD_W-1:0] sc_s2;
	logic signed [ACC_W-1:0]  p2_s3;
	logic signed [WORD_W-1:0] rf_s3;
	logic signed [ACC_W-1:0]  p3_s4;
	logic                     v_s1, v_s2, v_s3, v_s4;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  old_prod;
	logic signed [WORD_W-1:0] term;
	logic                     ld_ok_left;
	logic                     ld_ok_right;
	logic                     ld_ok_rank;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= 32'sd65536;
			beta_q      <= '0;
			rank_used_q <= CNT_W'(MAX_RANK);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ALPHA: alpha_q     <= cfg_data;
				REG_BETA:  beta_q      <= cfg_data;
				REG_RANK:  rank_used_q <= cfg_data[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	assign status.rank_eff  = (rank_used_q > CNT_W'(MAX_RANK)) ? CNT_W'(MAX_RANK) : rank_used_q;
	assign status.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;

	// stores
	assign ld_ok_left  = (32'(factor_index) < MAX_RANK) && (32'(row_index) < ROWS);
	assign ld_ok_right = (32'(factor_index) < MAX_RANK) && (32'(column_index) < COLS);
	assign ld_ok_rank  = (32'(factor_index) < MAX_RANK);

	slru_ram #(.DEPTH(LEFT_DEPTH), .WIDTH(WORD_W)) u_left (
		.clk   (clk),
		.we    (cmd.ld_left && ld_ok_left),
		.waddr ({factor_index, row_index}),
		.wdata (data_word),
		.re    (cmd.issue),
		.raddr ({cmd.rank_pos, row_q}),
		.rdata (lf_s1)
	);

	slru_ram #(.DEPTH(RIGHT_DEPTH), .WIDTH(WORD_W)) u_right (
		.clk   (clk),
		.we    (cmd.ld_right && ld_ok_right),
		.waddr ({factor_index, column_index}),
		.wdata (data_word),
		.re    (cmd.issue),
		.raddr ({cmd.rank_pos, col_q}),
		.rdata (rf_s1)
	);

	slru_ram #(.DEPTH(MAX_RANK), .WIDTH(WORD_W)) u_scale (
		.clk   (clk),
		.we    (cmd.ld_scale && ld_ok_rank),
		.waddr (factor_index),
		.wdata (data_word),
		.re    (cmd.issue),
		.raddr (cmd.rank_pos),
		.rdata (sc_s1)
	);

	// update item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q    <= row_index;
			col_q    <= column_index;
			row_ok_q <= 32'(row_index) < ROWS;
			col_ok_q <= 32'(column_index) < COLS;
			old_q    <= data_word;
		end
	end

	// term pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// term pipeline payload
	always_ff @(posedge clk) begin
		p1_s2 <= alpha_q * (row_ok_q ? lf_s1 : 32'sd0);
		rf_s2 <= col_ok_q ? rf_s1 : '0;
		sc_s2 <= sc_s1;
		p2_s3 <= q16_sat(p1_s2) * sc_s2;
		rf_s3 <= rf_s2;
		p3_s4 <= q16_sat(p2_s3) * rf_s3;
	end

	assign old_prod = old_q * beta_q;
	assign term     = q16_sat(p3_s4);

	always_ff @(posedge clk) begin
		if (cmd.init_acc) begin
			acc_q <= old_prod >>> FRAC_W;
		end else if (v_s4) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			saturated <= !((&acc_q[ACC_W-1:WORD_W-1]) || !(|acc_q[ACC_W-1:WORD_W-1]));
			if ((&acc_q[ACC_W-1:WORD_W-1]) || !(|acc_q[ACC_W-1:WORD_W-1])) begin
				new_value <= acc_q[WORD_W-1:0];
			end else if (acc_q[ACC_W-1]) begin
				new_value <= {1'b1, {(WORD_W-1){1'b0}}};
			end else begin
				new_value <= {1'b0, {(WORD_W-1){1'b1}}};
			end
		end
	end

endmodule

`default_nettype wire

[rtl/slru_ctrl.sv]
// ---------------------------------------------------------------------------
// slru_ctrl
// Controller: takes input beats, issues rank positions into the term
// pipeline, waits for it to drain and hands the result to the output.
// ---------------------------------------------------------------------------
`default_nettype none

module slru_ctrl
	import slru_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [1:0]   in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire slru_status_t status,
	output slru_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_fire;
	logic             out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.ld_left  = in_fire && (func_t'(in_func) == FUNC_LEFT);
		cmd.ld_right = in_fire && (func_t'(in_func) == FUNC_RIGHT);
		cmd.ld_scale = in_fire && (func_t'(in_func) == FUNC_SCALE);
		cmd.capture  = in_fire && (func_t'(in_func) == FUNC_UPDATE);
		cmd.init_acc = (state_q == ST_INIT);
		cmd.issue    = (state_q == ST_RUN) && (cnt_q < status.rank_eff);
		cmd.rank_pos = cnt_q[RANK_W-1:0];
		cmd.load_out = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q < status.rank_eff) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.pipe_busy)
		else $error("result taken while terms still in flight");

	a_issue_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (CNT_W'(cmd.rank_pos) < status.rank_eff))
		else $error("rank position issued beyond rank");

	a_update_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("input taken during an update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.load_out)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
